[rtl/bmp24_to_rgb565_centered_streamer_macros.svh]
// assertion helpers used by the rtl
`ifndef BMP24_TO_RGB565_CENTERED_STREAMER_MACROS_SVH
`define BMP24_TO_RGB565_CENTERED_STREAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bmp_pkg;
    localparam int DEF_PANEL_W     = 128;
    localparam int DEF_PANEL_H     = 160;
    localparam int DEF_MAX_IMAGE_W = 1280;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [1:0] KIND_WINDOW = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col_first;
        logic [7:0]  col_final;
        logic [7:0]  panel_row;
        logic [15:0] pixel;
        logic        last;
    } t_res;

    // one queue entry: the results caused by one file byte
    typedef struct packed {
        logic has2;
        t_res r0;
        t_res r1;
    } t_job;
endpackage
`default_nettype wire

[rtl/bmp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bmp_front import bmp_pkg::*; #(
    parameter int PANEL_W     = DEF_PANEL_W,
    parameter int PANEL_H     = DEF_PANEL_H,
    parameter int MAX_IMAGE_W = DEF_MAX_IMAGE_W
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    output t_job            o_job,
    output logic            o_push
);
    localparam int WW  = $clog2(MAX_IMAGE_W + 1);
    localparam int RBW = $clog2(3 * MAX_IMAGE_W + 4);
    localparam int DWW = $clog2(PANEL_W + 1);
    localparam logic [31:0] PW32 = 32'(PANEL_W);
    localparam logic [31:0] PH32 = 32'(PANEL_H);
    localparam logic [31:0] MW32 = 32'(MAX_IMAGE_W);

    logic [2:0]     r_phase, n_phase;
    logic [31:0]    r_pos, n_pos;
    logic [31:0]    r_off, n_off;
    logic [31:0]    r_w, n_w;
    logic [31:0]    r_h, n_h;
    logic [63:0]    r_chk, n_chk;
    logic [31:0]    r_skip, n_skip;
    logic [7:0]     r_row, n_row;
    logic [DWW-1:0] r_col, n_col;
    logic [RBW-1:0] r_bir, n_bir;
    logic [15:0]    r_part, n_part;
    logic [1:0]     r_ci, n_ci;
    logic [RBW-1:0] r_rb, n_rb;
    logic [DWW-1:0] r_drawn, n_drawn;
    logic [7:0]     r_cs, n_cs;
    logic [7:0]     r_ce, n_ce;
    logic [7:0]     r_rs, n_rs;

    always_comb begin
        logic [5:0]    p;
        logic          bad;
        logic [WW-1:0] w;
        logic          wide;
        logic          tall;
        logic [1:0]    nres;
        logic          fin;
        t_res          res;
        n_phase = r_phase; n_pos = r_pos; n_off = r_off; n_w = r_w; n_h = r_h;
        n_chk = r_chk; n_skip = r_skip; n_row = r_row; n_col = r_col; n_bir = r_bir;
        n_part = r_part; n_ci = r_ci; n_rb = r_rb; n_drawn = r_drawn; n_cs = r_cs;
        n_ce = r_ce; n_rs = r_rs;
        o_job = '0;
        nres = 2'd0;
        fin = 1'b0;
        res = '0;
        p = r_pos[5:0];
        bad = 1'b0;
        w = '0;
        wide = 1'b0;
        tall = 1'b0;
        if (i_accept) begin
            // a start byte clears the parse state and is byte 0 of the header
            if (i_start) begin
                n_phase = PH_HEADER; n_pos = '0; n_off = '0; n_w = '0; n_h = '0;
                n_chk = '0; n_skip = '0; n_row = '0; n_col = '0; n_bir = '0;
                n_part = '0; n_ci = '0;
                p = '0;
            end
            if (n_phase == PH_GAP) begin
                if (n_pos < n_off) begin
                    n_pos = n_pos + 32'd1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            if (n_phase == PH_HEADER) begin
                if (p >= 6'd10 && p <= 6'd13) n_off[8*(p-6'd10) +: 8] = i_byte;
                else if (p >= 6'd18 && p <= 6'd21) n_w[8*(p-6'd18) +: 8] = i_byte;
                else if (p >= 6'd22 && p <= 6'd25) n_h[8*(p-6'd22) +: 8] = i_byte;
                else if (p >= 6'd26 && p <= 6'd33) n_chk[8*(p-6'd26) +: 8] = i_byte;
                n_pos = n_pos + 32'd1;
                if (p == 6'd33) begin
                    bad = (n_chk[15:0] != 16'd1) || (n_chk[31:16] != 16'd24) ||
                          (n_chk[63:32] != 32'd0) || (n_w == 32'd0) ||
                          (n_w > MW32) || (n_h == 32'd0);
                    if (bad) begin
                        res.kind = KIND_REJECT;
                        res.last = 1'b1;
                        o_job.r0 = res;
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end else begin
                        w = n_w[WW-1:0];
                        wide = n_w > PW32;
                        tall = n_h > PH32;
                        n_rb = RBW'((32'(w) * 32'd3 + 32'd3) & ~32'd3);
                        n_drawn = wide ? DWW'(PANEL_W) : DWW'(w);
                        n_cs = wide ? 8'd0 : 8'((PW32 - 32'(w)) >> 1);
                        n_ce = wide ? 8'(PANEL_W - 1) : 8'(32'(n_cs) + 32'(w) - 32'd1);
                        n_rs = tall ? 8'd0 : 8'((PH32 - n_h) >> 1);
                        n_row = tall ? 8'(PANEL_H - 1) : 8'(32'(n_rs) + n_h - 32'd1);
                        n_skip = tall ? n_h - PH32 : 32'd0;
                        n_col = '0; n_bir = '0; n_part = '0; n_ci = '0;
                        n_phase = PH_GAP;
                    end
                end
            end else if (n_phase == PH_DATA) begin
                if (n_skip != 32'd0) begin
                    n_bir = n_bir + RBW'(1);
                    if (n_bir >= n_rb) begin
                        n_bir = '0;
                        n_skip = n_skip - 32'd1;
                    end
                end else begin
                    if (n_bir == '0) begin
                        res = '0;
                        res.kind = KIND_WINDOW;
                        res.col_first = n_cs;
                        res.col_final = n_ce;
                        res.panel_row = n_row;
                        o_job.r0 = res;
                        nres = 2'd1;
                    end
                    if (n_col < n_drawn) begin
                        unique case (n_ci)
                            2'd0: begin
                                n_part = {11'd0, i_byte[7:3]};
                                n_ci = 2'd1;
                            end
                            2'd1: begin
                                n_part = n_part | {5'd0, i_byte[7:2], 5'd0};
                                n_ci = 2'd2;
                            end
                            default: begin
                                res = '0;
                                res.kind = KIND_PIXEL;
                                res.pixel = n_part | {i_byte[7:3], 11'd0};
                                if (nres == 2'd0) o_job.r0 = res;
                                else o_job.r1 = res;
                                nres = nres + 2'd1;
                                n_ci = 2'd0;
                                n_part = '0;
                                n_col = n_col + DWW'(1);
                                if (n_col >= n_drawn && n_row <= n_rs) begin
                                    res = '0;
                                    res.kind = KIND_DONE;
                                    res.last = 1'b1;
                                    o_job.r1 = res;
                                    nres = 2'd2;
                                    n_phase = PH_DONE;
                                    fin = 1'b1;
                                end
                            end
                        endcase
                    end
                    if (!fin) begin
                        n_bir = n_bir + RBW'(1);
                        if (n_bir >= n_rb) begin
                            n_bir = '0;
                            n_col = '0;
                            n_ci = '0;
                            n_row = n_row - 8'd1;
                        end
                    end
                end
            end
        end
        o_job.has2 = nres == 2'd2;
        o_push = nres != 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pos <= '0; r_off <= '0; r_w <= '0; r_h <= '0;
            r_chk <= '0; r_skip <= '0; r_row <= '0; r_col <= '0; r_bir <= '0;
            r_part <= '0; r_ci <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_off <= n_off; r_w <= n_w; r_h <= n_h;
            r_chk <= n_chk; r_skip <= n_skip; r_row <= n_row; r_col <= n_col;
            r_bir <= n_bir; r_part <= n_part; r_ci <= n_ci;
        end
    end

    // geometry derived once per file
    always_ff @(posedge i_clk) begin
        r_rb <= n_rb; r_drawn <= n_drawn; r_cs <= n_cs; r_ce <= n_ce; r_rs <= n_rs;
    end
endmodule
`default_nettype wire

[rtl/bmp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bmp24_to_rgb565_centered_streamer_macros.svh"
module bmp_fifo import bmp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);
    t_job          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + Q_AW'(1);
            if (do_pop) r_rp <= r_rp + Q_AW'(1);
            r_cnt <= r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    `BMP_ASSERT_NOW(a_no_overflow, i_push, !o_full, "push into full queue")
    `BMP_ASSERT_NOW(a_no_underflow, i_pop, !o_empty, "pop from empty queue")
    `BMP_ASSERT_NOW(a_cnt_ptr, 1'b1, r_wp == Q_AW'(r_rp + r_cnt[Q_AW-1:0]),
        "queue pointers disagree with count")
endmodule
`default_nettype wire

[rtl/bmp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bmp_back import bmp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);
    logic r_valid, r_sel, load;
    t_res r_res;

    assign load    = (!r_valid || i_ready) && !i_empty;
    // the entry leaves once its final result is loaded
    assign o_pop   = load && (r_sel || !i_job.has2);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !o_pop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= r_sel ? i_job.r1 : i_job.r0;
    end
endmodule
`default_nettype wire

[rtl/bmp24_to_rgb565_centered_streamer.sv]
`timescale 1ns / 1ps
`default_nettype none
// accepted bytes' results are queued, then sent one at a time from an output register
// throughput: one file byte per cycle while the 4-entry result queue has room;
//   the result port moves one result per cycle while i_m_tready is high
// reset: synchronous active-low i_rst_n clears the parser to idle and empties the queue
module bmp24_to_rgb565_centered_streamer import bmp_pkg::*; #(
    parameter int PANEL_W     = DEF_PANEL_W,
    parameter int PANEL_H     = DEF_PANEL_H,
    parameter int MAX_IMAGE_W = DEF_MAX_IMAGE_W
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // file_byte
    input  wire logic        i_s_tuser,   // file_start
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // col_first, col_final, panel_row, pixel
    output logic [1:0]       o_m_tuser,   // kind
    output logic             o_m_tlast    // last
);
    t_job job_in, job_out;
    t_res res;
    logic push, pop, q_empty, q_full, accept;

    // a byte is taken only when its results are sure to fit in the queue
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // front: header capture, geometry, row and column walk
    bmp_front #(
        .PANEL_W(PANEL_W), .PANEL_H(PANEL_H), .MAX_IMAGE_W(MAX_IMAGE_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_byte(i_s_tdata), .i_start(i_s_tuser), .o_job(job_in), .o_push(push)
    );

    // short queue decoupling the parser from the result port
    bmp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in),
        .i_pop(pop), .o_job(job_out), .o_empty(q_empty), .o_full(q_full)
    );

    // back: splits each entry into single results on a registered output
    bmp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(job_out), .i_empty(q_empty),
        .o_pop(pop), .o_valid(o_m_tvalid), .i_ready(i_m_tready), .o_res(res)
    );

    assign o_m_tdata = {res.pixel, res.panel_row, res.col_final, res.col_first};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;
endmodule
`default_nettype wire
